/* rtl/lti_pkg.sv */
`timescale 1ns / 1ps
package lti_pkg;

  // Grid capacity
  localparam int MAX_BANDS        = 8;
  localparam int MAX_ANGLE_POINTS = 16;
  localparam int MAX_DUST_POINTS  = 16;
  localparam int MAX_GRAIN_POINTS = 16;

  // Widths
  localparam int VAL_W   = 24;  // Q16.8 coordinate
  localparam int REF_W   = 16;  // Q0.16 table value
  localparam int FRAC_W  = 16;
  localparam int PT_W    = 4;   // grid position
  localparam int NPT_W   = 5;   // grid point count
  localparam int BAND_W  = 4;
  localparam int TBL_AW  = 15;
  localparam int CRD_AW  = 6;
  localparam int QUO_W   = 21;  // fraction quotient, larger is always off grid

  // Coordinate store layout
  localparam logic [CRD_AW-1:0] DUST_BASE  = CRD_AW'(MAX_ANGLE_POINTS);
  localparam logic [CRD_AW-1:0] GRAIN_BASE = CRD_AW'(MAX_ANGLE_POINTS + MAX_DUST_POINTS);

  // Operations
  localparam logic [1:0] OP_WR_TABLE = 2'd0;
  localparam logic [1:0] OP_WR_COORD = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  // Axis codes
  localparam logic [1:0] AXIS_ANGLE = 2'd0;
  localparam logic [1:0] AXIS_DUST  = 2'd1;
  localparam logic [1:0] AXIS_GRAIN = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_BANDS = 2'd0;
  localparam logic [1:0] REG_ANGLE = 2'd1;
  localparam logic [1:0] REG_DUST  = 2'd2;
  localparam logic [1:0] REG_GRAIN = 2'd3;

  typedef struct packed {
    logic [1:0]       axis;
    logic [NPT_W-1:0] npts;
    logic [VAL_W-1:0] value;
  } axis_req_t;

  typedef struct packed {
    logic              bad;
    logic [PT_W-1:0]   pos;
    logic [FRAC_W-1:0] frac;
  } axis_res_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [NPT_W-1:0]  na;
    logic [NPT_W-1:0]  nd;
    logic [NPT_W-1:0]  ng;
    logic [PT_W-1:0]   a1;
    logic [PT_W-1:0]   d1;
    logic [PT_W-1:0]   g1;
    logic [FRAC_W-1:0] fa;
    logic [FRAC_W-1:0] fd;
    logic [FRAC_W-1:0] fg;
  } blend_req_t;

endpackage

/* rtl/lti_axis_unit.sv */
`timescale 1ns / 1ps
// Coordinate store plus per-axis bracket search and fraction divider
module lti_axis_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [lti_pkg::CRD_AW-1:0]    wr_addr,
  input  logic [lti_pkg::VAL_W-1:0]     wr_data,
  input  logic                          start,
  input  lti_pkg::axis_req_t            req,
  output logic                          done,
  output lti_pkg::axis_res_t            res
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_LO   = 4'd2;
  localparam logic [3:0] S_HI   = 4'd3;
  localparam logic [3:0] S_PREP = 4'd4;
  localparam logic [3:0] S_DIV0 = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;

  logic [lti_pkg::VAL_W-1:0]  mem [2**lti_pkg::CRD_AW];
  logic [lti_pkg::VAL_W-1:0]  rd_data;
  logic [lti_pkg::CRD_AW-1:0] raddr;

  logic [3:0]                 state;
  lti_pkg::axis_req_t         rq;
  logic [lti_pkg::CRD_AW-1:0] base;
  logic [lti_pkg::PT_W-1:0]   k;
  logic [lti_pkg::PT_W-1:0]   kk;
  logic [lti_pkg::VAL_W-1:0]  lo;
  logic signed [24:0]         num, den;
  logic                       neg;
  logic [41:0]                x;
  logic [25:0]                y;
  logic [25:0]                rem;
  logic [20:0]                xl;
  logic [lti_pkg::QUO_W-1:0]  quo;
  logic [4:0]                 cnt;

  logic [lti_pkg::NPT_W-1:0]  nm1;
  logic [lti_pkg::PT_W-1:0]   kcap;
  logic [26:0]                rem2;
  logic [23:0]                an, ad;
  logic signed [23:0]         idx;
  logic [23:0]                kx;

  // Coordinate memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[raddr];
  end

  assign nm1  = rq.npts - 5'd1;
  assign kcap = ({1'b0, k} >= nm1) ? lti_pkg::PT_W'(rq.npts - 5'd2) : k;
  assign rem2 = {rem, xl[20]};
  assign an   = num[24] ? 24'(-num) : 24'(num);
  assign ad   = den[24] ? 24'(-den) : 24'(den);
  assign kx   = {4'd0, kk, 16'd0};
  assign idx  = neg ? signed'(kx - 24'(quo)) : signed'(kx + 24'(quo));

  // Read address
  always_comb begin
    logic [lti_pkg::CRD_AW-1:0] b;
    case (req.axis)
      lti_pkg::AXIS_DUST:  b = lti_pkg::DUST_BASE;
      lti_pkg::AXIS_GRAIN: b = lti_pkg::GRAIN_BASE;
      default:             b = '0;
    endcase
    case (state)
      S_IDLE:  raddr = b;
      S_SCAN:  raddr = (rd_data < rq.value && {1'b0, k} < nm1) ?
                       base + lti_pkg::CRD_AW'(k + 4'd1) : base + lti_pkg::CRD_AW'(kcap);
      S_LO:    raddr = base + lti_pkg::CRD_AW'(kk) + 6'd1;
      default: raddr = base;
    endcase
  end

  // Search, bracket read, restoring division
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            rq <= req;
            case (req.axis)
              lti_pkg::AXIS_DUST:  base <= lti_pkg::DUST_BASE;
              lti_pkg::AXIS_GRAIN: base <= lti_pkg::GRAIN_BASE;
              default:             base <= '0;
            endcase
            k     <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_data < rq.value && {1'b0, k} < nm1) begin
            k <= k + 4'd1;
          end else begin
            kk    <= kcap;
            state <= S_LO;
          end
        end
        S_LO: begin
          lo    <= rd_data;
          state <= S_HI;
        end
        S_HI: begin
          num   <= signed'({1'b0, rq.value}) - signed'({1'b0, lo});
          den   <= signed'({1'b0, rd_data}) - signed'({1'b0, lo});
          state <= S_PREP;
        end
        S_PREP: begin
          neg <= num[24] ^ den[24];
          x   <= {1'b0, an, 17'd0} + 42'(ad);
          y   <= {1'b0, ad, 1'b0};
          quo <= '0;
          if (num == '0) begin
            state <= S_FIN;
          end else if (den == '0) begin
            res.bad <= 1'b1;
            done    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            state <= S_DIV0;
          end
        end
        S_DIV0: begin
          if (26'(x[41:21]) >= y) begin
            res.bad <= 1'b1;
            done    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            rem   <= 26'(x[41:21]);
            xl    <= x[20:0];
            cnt   <= 5'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, y}) begin
            rem <= 26'(rem2 - {1'b0, y});
            quo <= {quo[19:0], 1'b1};
          end else begin
            rem <= rem2[25:0];
            quo <= {quo[19:0], 1'b0};
          end
          xl  <= {xl[19:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(lti_pkg::QUO_W - 1)) state <= S_FIN;
        end
        S_FIN: begin
          res.bad  <= idx[23] || (idx > signed'({4'd0, nm1[3:0], 16'd0}));
          res.pos  <= idx[19:16];
          res.frac <= idx[15:0];
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/lti_blend.sv */
`timescale 1ns / 1ps
// Table memory, corner address generation and the seven-step lerp tree
module lti_blend (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [lti_pkg::TBL_AW-1:0]    wr_addr,
  input  logic [lti_pkg::REF_W-1:0]     wr_data,
  input  logic                          start,
  input  lti_pkg::blend_req_t           req,
  output logic                          done,
  output logic [lti_pkg::REF_W-1:0]     result
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MA   = 3'd1;
  localparam logic [2:0] B_MD   = 3'd2;
  localparam logic [2:0] B_MG   = 3'd3;
  localparam logic [2:0] B_RD   = 3'd4;
  localparam logic [2:0] B_LERP = 3'd5;

  logic [lti_pkg::REF_W-1:0]  mem [2**lti_pkg::TBL_AW];
  logic [lti_pkg::REF_W-1:0]  rd_data;
  logic [lti_pkg::TBL_AW-1:0] raddr;

  logic [2:0]                 state;
  lti_pkg::blend_req_t        rq;
  lti_pkg::blend_req_t        rq_in;
  logic [lti_pkg::PT_W-1:0]   a2, d2, g2;
  logic [lti_pkg::PT_W-1:0]   a2_in, d2_in, g2_in;
  logic [8:0]                 pa0, pa1;
  logic [13:0]                qd [4];
  logic [18:0]                rb [4];
  logic [3:0]                 rc;
  logic [lti_pkg::REF_W-1:0]  v [8];
  logic [lti_pkg::REF_W-1:0]  rr [6];
  logic [2:0]                 s;
  logic                       ph;
  logic signed [33:0]         t;
  logic [lti_pkg::REF_W-1:0]  la;

  logic [lti_pkg::REF_W-1:0]  opa, opb, opf;
  logic [18:0]                rsel;
  logic [13:0]                pn0, pn1;
  logic [33:0]                mag;
  logic [17:0]                rm;
  logic signed [18:0]         lsum;
  logic [lti_pkg::REF_W-1:0]  lres;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[raddr];
  end

  // Upper neighbours; a clamped one carries no weight
  always_comb begin
    rq_in = req;
    a2_in = req.a1 + 4'd1;
    d2_in = req.d1 + 4'd1;
    g2_in = req.g1 + 4'd1;
    if ({1'b0, req.a1} + 5'd1 >= req.na) begin
      a2_in    = req.a1;
      rq_in.fa = '0;
    end
    if ({1'b0, req.d1} + 5'd1 >= req.nd) begin
      d2_in    = req.d1;
      rq_in.fd = '0;
    end
    if ({1'b0, req.g1} + 5'd1 >= req.ng) begin
      g2_in    = req.g1;
      rq_in.fg = '0;
    end
  end

  // Corner address for read rc
  always_comb begin
    case (rc[2:1])
      2'd0:    rsel = rb[0];
      2'd1:    rsel = rb[1];
      2'd2:    rsel = rb[2];
      default: rsel = rb[3];
    endcase
    raddr = rsel[14:0] + lti_pkg::TBL_AW'(rc[0] ? g2 : rq.g1);
  end

  assign pn0 = pa0 * rq.nd;
  assign pn1 = pa1 * rq.nd;

  // Lerp operands per step: grain first, then dust, then angle
  always_comb begin
    case (s)
      3'd0:    begin opa = v[0];  opb = v[1];  opf = rq.fg; end
      3'd1:    begin opa = v[2];  opb = v[3];  opf = rq.fg; end
      3'd2:    begin opa = v[4];  opb = v[5];  opf = rq.fg; end
      3'd3:    begin opa = v[6];  opb = v[7];  opf = rq.fg; end
      3'd4:    begin opa = rr[0]; opb = rr[1]; opf = rq.fd; end
      3'd5:    begin opa = rr[2]; opb = rr[3]; opf = rq.fd; end
      default: begin opa = rr[4]; opb = rr[5]; opf = rq.fa; end
    endcase
  end

  // Round half away from zero, then add
  assign mag  = t[33] ? 34'(-t) : 34'(t);
  assign rm   = 18'((mag + 34'd32768) >> 16);
  assign lsum = signed'({3'd0, la}) + (t[33] ? -signed'({1'b0, rm}) : signed'({1'b0, rm}));
  assign lres = lsum[18] ? '0 : (lsum > 19'sd65535 ? 16'hFFFF : lsum[15:0]);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (start) begin
            rq    <= rq_in;
            a2    <= a2_in;
            d2    <= d2_in;
            g2    <= g2_in;
            state <= B_MA;
          end
        end
        B_MA: begin
          pa0   <= 9'((rq.band - 4'd1) * rq.na) + 9'(rq.a1);
          pa1   <= 9'((rq.band - 4'd1) * rq.na) + 9'(a2);
          state <= B_MD;
        end
        B_MD: begin
          qd[0] <= pn0 + 14'(rq.d1);
          qd[1] <= pn0 + 14'(d2);
          qd[2] <= pn1 + 14'(rq.d1);
          qd[3] <= pn1 + 14'(d2);
          state <= B_MG;
        end
        B_MG: begin
          for (int j = 0; j < 4; j++) rb[j] <= qd[j] * rq.ng;
          rc    <= '0;
          state <= B_RD;
        end
        B_RD: begin
          rc <= rc + 4'd1;
          if (rc != 4'd0) begin
            for (int j = 0; j < 7; j++) v[j] <= v[j+1];
            v[7] <= rd_data;
          end
          if (rc == 4'd8) begin
            s     <= '0;
            ph    <= 1'b0;
            state <= B_LERP;
          end
        end
        B_LERP: begin
          ph <= ~ph;
          if (!ph) begin
            t  <= (signed'({1'b0, opb}) - signed'({1'b0, opa})) * signed'({1'b0, opf});
            la <= opa;
          end else begin
            case (s)
              3'd0:    rr[0] <= lres;
              3'd1:    rr[1] <= lres;
              3'd2:    rr[2] <= lres;
              3'd3:    rr[3] <= lres;
              3'd4:    rr[4] <= lres;
              3'd5:    rr[5] <= lres;
              default: begin
                result <= lres;
                done   <= 1'b1;
                state  <= B_IDLE;
              end
            endcase
            s <= s + 3'd1;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* rtl/lut_trilinear_interpolation.sv */
`timescale 1ns / 1ps
// Trilinear reflectance lookup.
// Input beats (s_*): tuser carries the operation. Table writes and coordinate
// writes are stored on the beat and give no result. A query gives one result
// beat on m_*: reflectance in m_tdata, out-of-range flag in m_tuser.
// A query runs a pass per axis, then the blend. Per axis: a bracket search
// reading one coordinate a cycle (up to 16), two bracket reads and a
// bit-serial divider for a 21-bit quotient, skipped on grid points and cut
// short by an early flag. Blend: three small multiply steps, eight table
// reads from the single table port and seven lerps; flagged queries skip it.
// One item is worked at a time; s_tready is high only while idle.
// The result sits in an output register, so the block goes back to idle and
// takes the next beat while the result waits; if m_tready is low when a
// second query finishes, that query holds until the register frees.
// Reset (rst, synchronous) clears control state and sets the registers to
// their defaults; table and coordinate memories are not cleared and must be
// written before use. Registers are to be written over APB only while idle;
// the block itself does not enforce this.
module lut_trilinear_interpolation (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [1:0] axis_select, [16:2] entry_address, [40:17] entry_data,
  // [44:41] band_number, [68:45] angle_value, [92:69] dust_value,
  // [116:93] grain_value
  input  logic [119:0] s_tdata,
  input  logic [1:0]   s_tuser,   // [1:0] operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,   // [15:0] reflectance
  output logic         m_tuser,   // [0] out_of_range
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AXIS  = 3'd1;
  localparam logic [2:0] ST_BLEND = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;

  logic [2:0]  state;
  logic [3:0]  bands;
  logic [4:0]  angle_pts, dust_pts, grain_pts;

  logic [1:0]  axis;
  logic        bad;
  logic        fin_bad;
  logic [15:0] fin_val;
  logic [3:0]  band;
  logic [23:0] vals [3];
  lti_pkg::axis_res_t ares [3];

  logic                  in_beat;
  logic [1:0]            op;
  logic                  ax_start, ax_done;
  lti_pkg::axis_req_t    ax_req;
  lti_pkg::axis_res_t    ax_res;
  logic                  bl_start, bl_done;
  lti_pkg::blend_req_t   bl_req;
  logic [15:0]           bl_result;
  logic                  crd_we;
  logic [5:0]            crd_addr;
  logic                  cfg_wr;
  logic [3:0]            wb;
  logic [4:0]            wp;

  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign op       = s_tuser;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Config registers, saturated on write
  assign wb = (pwdata[3:0] < 4'd1) ? 4'd1 :
              (pwdata[3:0] > 4'(lti_pkg::MAX_BANDS)) ? 4'(lti_pkg::MAX_BANDS) : pwdata[3:0];
  assign wp = (pwdata[4:0] < 5'd2) ? 5'd2 :
              (pwdata[4:0] > 5'(lti_pkg::MAX_ANGLE_POINTS)) ? 5'(lti_pkg::MAX_ANGLE_POINTS)
              : pwdata[4:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      bands     <= 4'(lti_pkg::MAX_BANDS);
      angle_pts <= 5'(lti_pkg::MAX_ANGLE_POINTS);
      dust_pts  <= 5'(lti_pkg::MAX_DUST_POINTS);
      grain_pts <= 5'(lti_pkg::MAX_GRAIN_POINTS);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lti_pkg::REG_BANDS: bands     <= wb;
        lti_pkg::REG_ANGLE: angle_pts <= wp;
        lti_pkg::REG_DUST:  dust_pts  <= wp;
        default:            grain_pts <= wp;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lti_pkg::REG_BANDS: prdata = {28'd0, bands};
      lti_pkg::REG_ANGLE: prdata = {27'd0, angle_pts};
      lti_pkg::REG_DUST:  prdata = {27'd0, dust_pts};
      default:            prdata = {27'd0, grain_pts};
    endcase
  end

  // Coordinate write decode
  always_comb begin
    crd_we   = 1'b0;
    crd_addr = s_tdata[7:2];
    if (in_beat && op == lti_pkg::OP_WR_COORD && s_tdata[16:6] == '0) begin
      case (s_tdata[1:0])
        lti_pkg::AXIS_ANGLE: begin crd_we = 1'b1; crd_addr = {2'd0, s_tdata[5:2]}; end
        lti_pkg::AXIS_DUST: begin
          crd_we = 1'b1; crd_addr = lti_pkg::DUST_BASE + {2'd0, s_tdata[5:2]};
        end
        lti_pkg::AXIS_GRAIN: begin
          crd_we = 1'b1; crd_addr = lti_pkg::GRAIN_BASE + {2'd0, s_tdata[5:2]};
        end
        default: crd_we = 1'b0;
      endcase
    end
  end

  // Axis requests
  always_comb begin
    ax_req.axis = axis;
    case (axis)
      lti_pkg::AXIS_ANGLE: begin ax_req.npts = angle_pts; ax_req.value = vals[0]; end
      lti_pkg::AXIS_DUST:  begin ax_req.npts = dust_pts;  ax_req.value = vals[1]; end
      default:             begin ax_req.npts = grain_pts; ax_req.value = vals[2]; end
    endcase
  end

  assign bl_req = '{band: band, na: angle_pts, nd: dust_pts, ng: grain_pts,
                    a1: ares[0].pos, d1: ares[1].pos, g1: ares[2].pos,
                    fa: ares[0].frac, fd: ares[1].frac, fg: ares[2].frac};

  // Query sequencer
  always_ff @(posedge clk) begin
    ax_start <= 1'b0;
    bl_start <= 1'b0;
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // output register drains here; ST_FIN reloads it
      if (m_tvalid && m_tready && state != ST_FIN) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_beat && op == lti_pkg::OP_QUERY) begin
            band     <= s_tdata[44:41];
            vals[0]  <= s_tdata[68:45];
            vals[1]  <= s_tdata[92:69];
            vals[2]  <= s_tdata[116:93];
            bad      <= (s_tdata[44:41] == 4'd0) || (s_tdata[44:41] > bands);
            axis     <= lti_pkg::AXIS_ANGLE;
            ax_start <= 1'b1;
            state    <= ST_AXIS;
          end
        end
        ST_AXIS: begin
          if (ax_done) begin
            case (axis)
              lti_pkg::AXIS_ANGLE: ares[0] <= ax_res;
              lti_pkg::AXIS_DUST:  ares[1] <= ax_res;
              default:             ares[2] <= ax_res;
            endcase
            if (axis != lti_pkg::AXIS_GRAIN) begin
              bad      <= bad | ax_res.bad;
              axis     <= axis + 2'd1;
              ax_start <= 1'b1;
            end else if (bad || ax_res.bad) begin
              fin_bad <= 1'b1;
              fin_val <= '0;
              state   <= ST_FIN;
            end else begin
              bl_start <= 1'b1;
              state    <= ST_BLEND;
            end
          end
        end
        ST_BLEND: begin
          if (bl_done) begin
            fin_bad <= 1'b0;
            fin_val <= bl_result;
            state   <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= fin_val;
            m_tuser  <= fin_bad;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  lti_axis_unit u_axis (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (crd_we),
    .wr_addr (crd_addr),
    .wr_data (s_tdata[40:17]),
    .start   (ax_start),
    .req     (ax_req),
    .done    (ax_done),
    .res     (ax_res)
  );

  lti_blend u_blend (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_beat && op == lti_pkg::OP_WR_TABLE),
    .wr_addr (s_tdata[16:2]),
    .wr_data (s_tdata[32:17]),
    .start   (bl_start),
    .req     (bl_req),
    .done    (bl_done),
    .result  (bl_result)
  );

  // Checks
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 16'd0))
    else $error("flagged result carries nonzero value");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_beat && op == lti_pkg::OP_QUERY) |=> !s_tready)
    else $error("ready after query accept");

  a_axis_done: assert property (@(posedge clk) disable iff (rst)
    ax_done |-> (state == ST_AXIS))
    else $error("axis result outside axis phase");

  a_blend_done: assert property (@(posedge clk) disable iff (rst)
    bl_done |-> (state == ST_BLEND))
    else $error("blend result outside blend phase");

endmodule
